FILE: design/fixed_block_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// fixed block free list allocator assertion macros
// shorthand for clocked, reset-qualified concurrent assertions
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// property that must hold at every edge out of reset
`define FBFLA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in %m");

// implication: cons must hold in the cycle after ante
`define FBFLA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

FILE: design/fbfla_pkg.sv
// ----------------------------------------------------------------------------
// fbfla_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int unsigned POOL_SLOTS = 1024;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned IDX_W      = $clog2(POOL_SLOTS);
  // one code above the last slot marks the end of the list
  localparam int unsigned LINK_W     = $clog2(POOL_SLOTS + 1);

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_FREE   = 1'b1;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_EMPTY  = 1'b1;

  typedef struct packed {
    logic init_wr;    // write one entry of the clearing pass
    logic push;       // link returned slot to head, head takes slot
    logic read_head;  // fetch link of head slot
    logic pop;        // head follows fetched link
    logic res_free;   // result word: echoed slot, done
    logic res_empty;  // result word: zero, empty
    logic res_pop;    // result word: granted head slot, done
    logic out_load;   // move result word to output register
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic head_empty;
    logic slot_in_range;
  } status_t;

endpackage

FILE: design/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// lifo free list of fixed-size slots with allocate and free requests
// ----------------------------------------------------------------------------
// request channel: in_valid_i/in_stall_o carry op_i (0 allocate, 1 free) and
// slot_in_i (slot being returned, ignored on allocate). result channel:
// out_valid_o/out_stall_i carry slot_out_o and status_o (1 = pool empty).
// every request gives exactly one result word, in request order.
// allocate pops the head slot and the head follows its link in the link
// memory; free writes the old head into the slot's link and makes it head.
// a free of an index beyond the pool echoes the slot and changes nothing.
// free and refused allocate: result register, then output register. granted
// allocate: one registered link memory read first. one request at a time.
// reset: the link memory is chained in index order by a clearing pass over
// all 1024 entries, one entry a cycle; requests are stalled until it ends.
// a stalled result word holds in the output register; the next request is
// still accepted and processed, and waits for the register to drain.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [fbfla_pkg::SLOT_W-1:0] slot_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fbfla_pkg::SLOT_W-1:0] slot_out_o,
  output logic                         status_o
);

  fbfla_pkg::cmd_t    cmd;
  fbfla_pkg::status_t dp_status;

  fbfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (dp_status)
  );

  fbfla_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .slot_in_i    (slot_in_i),
    .slot_out_o   (slot_out_o),
    .status_out_o (status_o)
  );

endmodule

FILE: design/fbfla_datapath.sv
// ----------------------------------------------------------------------------
// fbfla_datapath
// head register, link memory, clearing-pass counter and result registers
// ----------------------------------------------------------------------------
module fbfla_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbfla_pkg::cmd_t                     cmd_i,
  output fbfla_pkg::status_t                  status_o,
  input  logic [fbfla_pkg::SLOT_W-1:0]        slot_in_i,
  output logic [fbfla_pkg::SLOT_W-1:0]        slot_out_o,
  output logic                                status_out_o
);

  logic [fbfla_pkg::LINK_W-1:0] link_mem [fbfla_pkg::POOL_SLOTS];

  logic [fbfla_pkg::LINK_W-1:0] head_q, head_d;
  logic [fbfla_pkg::LINK_W-1:0] rdata_q;
  logic [fbfla_pkg::IDX_W-1:0]  init_cnt_q;
  logic [fbfla_pkg::SLOT_W-1:0] res_slot_q, out_slot_q;
  logic                         res_st_q, out_st_q;

  assign status_o.init_last     = (init_cnt_q == fbfla_pkg::IDX_W'(fbfla_pkg::POOL_SLOTS - 1));
  assign status_o.head_empty    = (head_q == fbfla_pkg::LINK_W'(fbfla_pkg::POOL_SLOTS));
  assign status_o.slot_in_range = (32'(slot_in_i) < fbfla_pkg::POOL_SLOTS);

  always_comb begin
    head_d = head_q;
    if (cmd_i.push) begin
      head_d = fbfla_pkg::LINK_W'(slot_in_i);
    end else if (cmd_i.pop) begin
      head_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      init_cnt_q <= '0;
    end else begin
      head_q <= head_d;
      if (cmd_i.init_wr) begin
        init_cnt_q <= init_cnt_q + fbfla_pkg::IDX_W'(1);
      end
    end
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      link_mem[init_cnt_q] <= fbfla_pkg::LINK_W'(init_cnt_q) + fbfla_pkg::LINK_W'(1);
    end else if (cmd_i.push) begin
      link_mem[fbfla_pkg::IDX_W'(slot_in_i)] <= head_q;
    end
    if (cmd_i.read_head) begin
      rdata_q <= link_mem[head_q[fbfla_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_free) begin
      res_slot_q <= slot_in_i;
      res_st_q   <= fbfla_pkg::ST_DONE;
    end else if (cmd_i.res_empty) begin
      res_slot_q <= '0;
      res_st_q   <= fbfla_pkg::ST_EMPTY;
    end else if (cmd_i.res_pop) begin
      res_slot_q <= fbfla_pkg::SLOT_W'(head_q);
      res_st_q   <= fbfla_pkg::ST_DONE;
    end
    if (cmd_i.out_load) begin
      out_slot_q <= res_slot_q;
      out_st_q   <= res_st_q;
    end
  end

  assign slot_out_o   = out_slot_q;
  assign status_out_o = out_st_q;

endmodule

FILE: design/fbfla_ctrl.sv
// ----------------------------------------------------------------------------
// fbfla_ctrl
// request sequencer: clearing pass, request decode, output word handshake
// ----------------------------------------------------------------------------
module fbfla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fbfla_pkg::cmd_t    cmd_o,
  input  fbfla_pkg::status_t status_i
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_PUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (op_i == fbfla_pkg::OP_FREE) begin
            cmd_o.push     = status_i.slot_in_range;
            cmd_o.res_free = 1'b1;
            state_d        = S_PUT;
          end else if (status_i.head_empty) begin
            cmd_o.res_empty = 1'b1;
            state_d         = S_PUT;
          end else begin
            cmd_o.read_head = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.pop     = 1'b1;
        cmd_o.res_pop = 1'b1;
        state_d       = S_PUT;
      end
      S_PUT: begin
        // wait here until the output register can take the word
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/fbfla_checker.sv
// ----------------------------------------------------------------------------
// fbfla_checker
// port-level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_macros.svh"

module fbfla_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         op_i,
  input logic [fbfla_pkg::SLOT_W-1:0] slot_in_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [fbfla_pkg::SLOT_W-1:0] slot_out_o,
  input logic                         status_o
);

  logic out_held;
  logic out_empty;

  // result word held back by the receiver
  assign out_held  = out_valid_o && out_stall_i;
  assign out_empty = out_valid_o && (status_o == fbfla_pkg::ST_EMPTY);

  // a stalled result word keeps its valid
  `FBFLA_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_held, out_valid_o)

  // a stalled result word keeps its payload
  `FBFLA_ASSERT_NEXT(a_out_word_hold, clk_i, rst_ni, out_held, $stable({slot_out_o, status_o}))

  // one request at a time: busy right after an accepted word
  `FBFLA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a refused allocate reports slot zero
  `FBFLA_ASSERT(a_empty_slot_zero, clk_i, rst_ni, !out_empty || (slot_out_o == '0))

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (.*);
